// ----- sv/tcfr_pkg.sv -----
// Shared types and constants of the trigger chunk frame receiver.
// Depends on nothing; every other file refers to it by scoped names.
package tcfr_pkg;

	localparam int ByteW  = 8;
	localparam int IdxW   = 6;
	localparam int TickW  = 16;
	localparam int CfgIdxW = 2;

	// Largest chunk the byte_index field can describe.
	localparam int MaxChunk = 63;

	// Command queue between the front and the back.
	localparam int QDepth = 4;
	localparam int QAw    = 2;

	// Input opcodes.
	localparam logic OpByte = 1'b0;
	localparam logic OpTick = 1'b1;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CfgTimeout = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgBackoff = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgChunk   = 2'd2;

	// Configuration reset values.
	localparam logic [TickW-1:0] TimeoutRst = 16'd2000;
	localparam logic [TickW-1:0] BackoffRst = 16'd300;
	localparam logic [IdxW-1:0]  ChunkRst   = 6'd63;

	// One command for the back: an optional store write followed by an
	// optional frame emission whose last index is idx.
	typedef struct packed {
		logic             wr;
		logic             emit;
		logic [IdxW-1:0]  idx;
		logic [ByteW-1:0] data;
		logic             by_to;
	} tcfr_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tcfr_qstat_t;

endpackage

// ----- sv/tcfr_item_if.sv -----
// Input channel of the frame receiver: one received byte or one tick.
// Depends on tcfr_pkg for field widths.
interface tcfr_item_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [tcfr_pkg::ByteW-1:0]   rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ----- sv/tcfr_frame_if.sv -----
// Output channel of the frame receiver: one byte of an emitted frame.
// Depends on tcfr_pkg for field widths.
interface tcfr_frame_if;
	logic                        valid;
	logic                        ready;
	logic [tcfr_pkg::ByteW-1:0]  frame_byte;
	logic [tcfr_pkg::IdxW-1:0]   byte_index;
	logic                        frame_last;
	logic                        closed_by_timeout;

	modport source (output valid, output frame_byte, output byte_index,
		output frame_last, output closed_by_timeout, input ready);
	modport sink (input valid, input frame_byte, input byte_index,
		input frame_last, input closed_by_timeout, output ready);
endinterface

// ----- sv/tcfr_queue.sv -----
// Small command queue between the front and the back of the receiver.
// Depends on tcfr_pkg for the command type and the depth.
module tcfr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tcfr_pkg::tcfr_cmd_t   push_cmd,
	input  logic                  pop,
	output tcfr_pkg::tcfr_cmd_t   head,
	output tcfr_pkg::tcfr_qstat_t stat
);

	tcfr_pkg::tcfr_cmd_t         entry_q [tcfr_pkg::QDepth];
	logic [tcfr_pkg::QAw-1:0]    wr_ptr_q;
	logic [tcfr_pkg::QAw-1:0]    rd_ptr_q;
	logic [tcfr_pkg::QAw:0]      count_q;

	assign stat.full  = (count_q == (tcfr_pkg::QAw+1)'(tcfr_pkg::QDepth));
	assign stat.empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/tcfr_front.sv -----
// Front of the receiver: takes requests, tracks phase and counters, and
// queues store writes and frame emissions. Depends on tcfr_pkg and tcfr_item_if.
module tcfr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	tcfr_item_if.sink                       items,
	input  logic [tcfr_pkg::TickW-1:0]      timeout_ticks,
	input  logic [tcfr_pkg::TickW-1:0]      backoff_ticks,
	input  logic [tcfr_pkg::IdxW-1:0]       chunk_lim,
	input  tcfr_pkg::tcfr_qstat_t           qstat,
	output logic                            push,
	output tcfr_pkg::tcfr_cmd_t             push_cmd
);

	localparam logic [1:0] PhWait    = 2'd0;
	localparam logic [1:0] PhCollect = 2'd1;
	localparam logic [1:0] PhBackoff = 2'd2;

	logic [1:0]                   phase_q, phase_d;
	logic [tcfr_pkg::TickW-1:0]   tick_q, tick_d, tick_inc;
	logic [tcfr_pkg::TickW-1:0]   timeout_thr, backoff_thr;
	logic [tcfr_pkg::IdxW-1:0]    coll_q, coll_d, coll_inc;
	logic                         accept;
	logic                         need;

	assign items.ready = !qstat.full;
	assign accept      = items.valid && items.ready;
	assign push        = accept && need;

	assign tick_inc    = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
	assign coll_inc    = coll_q + 1'b1;
	assign timeout_thr = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
	assign backoff_thr = (backoff_ticks == '0) ? 16'd1 : backoff_ticks;

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		coll_d   = coll_q;
		need     = 1'b0;
		push_cmd = '{wr: 1'b0, emit: 1'b0, idx: coll_inc, data: items.rx_byte,
			by_to: 1'b0};
		if (items.opcode == tcfr_pkg::OpByte) begin
			unique case (phase_q)
				PhCollect: begin
					need        = 1'b1;
					push_cmd.wr = 1'b1;
					if (coll_inc >= chunk_lim) begin
						push_cmd.emit = 1'b1;
						phase_d = PhBackoff;
						tick_d  = '0;
						coll_d  = '0;
					end else begin
						coll_d = coll_inc;
					end
				end
				PhBackoff: begin
				end
				default: begin
					// Waiting, or the unused phase code: this is a trigger byte.
					need         = 1'b1;
					push_cmd.wr  = 1'b1;
					push_cmd.idx = '0;
					phase_d = PhCollect;
					tick_d  = '0;
					coll_d  = '0;
				end
			endcase
		end else begin
			unique case (phase_q)
				PhCollect: begin
					tick_d = tick_inc;
					if (tick_inc >= timeout_thr) begin
						tick_d = '0;
						if (coll_q != '0) begin
							need           = 1'b1;
							push_cmd.emit  = 1'b1;
							push_cmd.idx   = coll_q;
							push_cmd.by_to = 1'b1;
							phase_d = PhBackoff;
							coll_d  = '0;
						end else begin
							phase_d = PhWait;
						end
					end
				end
				PhBackoff: begin
					tick_d = tick_inc;
					if (tick_inc >= backoff_thr) begin
						tick_d  = '0;
						phase_d = PhWait;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhWait;
			tick_q  <= '0;
			coll_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			coll_q  <= coll_d;
		end
	end

endmodule

// ----- sv/tcfr_back.sv -----
// Back of the receiver: applies queued store writes and walks the frame
// store to send a frame out. Depends on tcfr_pkg and tcfr_frame_if.
module tcfr_back #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcfr_pkg::tcfr_cmd_t   head,
	input  tcfr_pkg::tcfr_qstat_t qstat,
	output logic                  pop,
	tcfr_frame_if.source          frames
);

	localparam int Aw = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

	localparam logic [1:0] BIdle = 2'd0;
	localparam logic [1:0] BRead = 2'd1;
	localparam logic [1:0] BShow = 2'd2;

	logic [tcfr_pkg::ByteW-1:0]  store_q [FRAME_DEPTH];
	logic [1:0]                  state_q;
	logic [tcfr_pkg::IdxW-1:0]   k_q;
	logic [tcfr_pkg::IdxW-1:0]   last_q;
	logic                        to_q;
	logic [tcfr_pkg::ByteW-1:0]  out_byte_q;
	logic [tcfr_pkg::IdxW-1:0]   out_idx_q;
	logic                        out_last_q;

	assign pop = (state_q == BIdle) && !qstat.empty;

	assign frames.valid             = (state_q == BShow);
	assign frames.frame_byte        = out_byte_q;
	assign frames.byte_index        = out_idx_q;
	assign frames.frame_last        = out_last_q;
	assign frames.closed_by_timeout = to_q;

	// Frame store: written from the queue, read one registered byte at a time.
	always_ff @(posedge clk) begin
		if (pop && head.wr) begin
			store_q[Aw'(head.idx)] <= head.data;
		end
		if (state_q == BRead) begin
			out_byte_q <= store_q[Aw'(k_q)];
			out_idx_q  <= k_q;
			out_last_q <= (k_q == last_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BIdle;
			k_q     <= '0;
			last_q  <= '0;
			to_q    <= 1'b0;
		end else begin
			unique case (state_q)
				BIdle: begin
					if (pop && head.emit) begin
						last_q  <= head.idx;
						to_q    <= head.by_to;
						k_q     <= '0;
						state_q <= BRead;
					end
				end
				BRead: begin
					state_q <= BShow;
				end
				BShow: begin
					if (frames.ready) begin
						if (k_q == last_q) begin
							state_q <= BIdle;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= BRead;
						end
					end
				end
				default: begin
					state_q <= BIdle;
				end
			endcase
		end
	end

endmodule

// ----- sv/trigger_chunk_frame_receiver.sv -----
// Trigger chunk frame receiver, top level. A request is taken while the command queue has
// room; a frame's first byte passes the queue, the back's store read and its output registers
// after the request that closes it, once the back is free. Throughput: one request a cycle at
// the input while the queue has room; the back reads each frame byte from the store, then
// presents it until the sink takes it. Reset clears phase, counters, queue and the registers
// to their defaults; the frame store keeps no reset and is written before use.
module trigger_chunk_frame_receiver #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	tcfr_item_if.sink                          items,
	tcfr_frame_if.source                       frames,
	input  logic                               cfg_we,
	input  logic [tcfr_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [tcfr_pkg::TickW-1:0]         cfg_data
);

	// The chunk limit can never exceed what the store holds after the
	// trigger byte, nor what byte_index can describe.
	localparam int LimCapInt = (FRAME_DEPTH - 1 < tcfr_pkg::MaxChunk) ?
		FRAME_DEPTH - 1 : tcfr_pkg::MaxChunk;
	localparam logic [tcfr_pkg::IdxW-1:0] LimCap = tcfr_pkg::IdxW'(LimCapInt);

	logic [tcfr_pkg::TickW-1:0] timeout_q;
	logic [tcfr_pkg::TickW-1:0] backoff_q;
	logic [tcfr_pkg::IdxW-1:0]  chunk_q;
	logic [tcfr_pkg::IdxW-1:0]  chunk_min;
	logic [tcfr_pkg::IdxW-1:0]  chunk_lim;

	tcfr_pkg::tcfr_cmd_t   push_cmd;
	tcfr_pkg::tcfr_cmd_t   head;
	tcfr_pkg::tcfr_qstat_t qstat;
	logic                  push;
	logic                  pop;

	// Configuration registers. An index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= tcfr_pkg::TimeoutRst;
			backoff_q <= tcfr_pkg::BackoffRst;
			chunk_q   <= tcfr_pkg::ChunkRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcfr_pkg::CfgTimeout: timeout_q <= cfg_data;
				tcfr_pkg::CfgBackoff: backoff_q <= cfg_data;
				tcfr_pkg::CfgChunk:   chunk_q   <= cfg_data[tcfr_pkg::IdxW-1:0];
				default: begin
				end
			endcase
		end
	end

	// A chunk size of zero behaves as one.
	assign chunk_min = (chunk_q == '0) ? 6'd1 : chunk_q;
	assign chunk_lim = (chunk_min > LimCap) ? LimCap : chunk_min;

	// The front classifies each request and queues store writes and
	// frame emissions; it stalls only when the queue is full.
	tcfr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.items         (items),
		.timeout_ticks (timeout_q),
		.backoff_ticks (backoff_q),
		.chunk_lim     (chunk_lim),
		.qstat         (qstat),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	tcfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	// The back owns the frame store, so writes and frame reads stay in
	// queue order and a new trigger never overwrites a frame in flight.
	tcfr_back #(
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.frames (frames)
	);

	// The queue status flags never contradict each other.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue reports full and empty at once");

	// Every frame holds the trigger byte and at least one more byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(frames.valid && frames.byte_index == '0) |-> !frames.frame_last)
		else $error("frame ended on its trigger byte");

	// Within a frame the byte after an accepted one follows at the next
	// index, with the same closing reason.
	assert property (@(posedge clk) disable iff (!arst_n)
		(frames.valid && frames.ready && !frames.frame_last) |-> ##2
		(frames.valid && frames.byte_index == $past(frames.byte_index, 2) + 6'd1 &&
		frames.closed_by_timeout == $past(frames.closed_by_timeout, 2)))
		else $error("frame bytes out of sequence");

endmodule
